FILE: hw/rtl/x86alu_pkg.sv
// ----------------------------------------------------------------------------
// x86alu_pkg: shared types, codes and helpers for the x86 integer ALU
// Function and size codes, flag bit positions, the structs that carry an
// operation down the pipeline, and the small helpers used by several stages.
// ----------------------------------------------------------------------------
package x86alu_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned FLAG_W = 6;

  // Flag bit positions in the flag word.
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 1;
  localparam int unsigned FLAG_AF = 2;
  localparam int unsigned FLAG_ZF = 3;
  localparam int unsigned FLAG_SF = 4;
  localparam int unsigned FLAG_OF = 5;

  typedef enum logic [3:0] {
    FUNC_ADD      = 4'd0,
    FUNC_SUB      = 4'd1,
    FUNC_CMP      = 4'd2,
    FUNC_AND      = 4'd3,
    FUNC_OR       = 4'd4,
    FUNC_XOR      = 4'd5,
    FUNC_INC      = 4'd6,
    FUNC_DEC      = 4'd7,
    FUNC_NOT      = 4'd8,
    FUNC_IMUL     = 4'd9,
    FUNC_BT       = 4'd10,
    FUNC_CONDTEST = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_DWORD = 2'd1,
    SIZE_QWORD = 2'd2
  } size_t;

  // Condition groups: the upper three bits of the Jcc code; bit 0 inverts.
  typedef enum logic [2:0] {
    COND_O  = 3'd0,
    COND_B  = 3'd1,
    COND_E  = 3'd2,
    COND_BE = 3'd3,
    COND_S  = 3'd4,
    COND_P  = 3'd5,
    COND_L  = 3'd6,
    COND_LE = 3'd7
  } cond_grp_t;

  // Flag update: only bits set in wmask are written.
  typedef struct packed {
    logic [FLAG_W-1:0] value;
    logic [FLAG_W-1:0] wmask;
  } flag_upd_t;

  // Per-operation control and non-multiply result.
  typedef struct packed {
    logic              is_mul;
    logic              is_cond;
    logic [3:0]        cond_code;
    logic [1:0]        size_code;
    logic              write_back;
    logic [DATA_W-1:0] result;
    flag_upd_t         upd;
  } alu_ctl_t;

  // Multiply partial products and sign-extended operands.
  typedef struct packed {
    logic [DATA_W-1:0] p00;
    logic [DATA_W-1:0] p01;
    logic [DATA_W-1:0] p10;
    logic [DATA_W-1:0] p11;
    logic [DATA_W-1:0] a_sx;
    logic [DATA_W-1:0] b_sx;
  } mul_pp_t;

  // Multiply column sums before the final high-word adjust.
  typedef struct packed {
    logic [33:0]       mid;
    logic [31:0]       lo_low;
    logic [DATA_W-1:0] hi_part;
    logic [DATA_W-1:0] corr;
  } mul_sum_t;

  // Full signed 128-bit product.
  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } mul_prod_t;

  // Mask for the operand size; the unused size code acts as 64-bit.
  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SIZE_BYTE:  m = {{(DATA_W-8){1'b0}}, 8'hFF};
      SIZE_DWORD: m = {{(DATA_W-32){1'b0}}, 32'hFFFF_FFFF};
      default:    m = '1;
    endcase
    return m;
  endfunction

  // Sign bit of a value at the operand size.
  function automatic logic sign_of(input logic [DATA_W-1:0] x, input logic [1:0] sz);
    logic s;
    case (sz)
      SIZE_BYTE:  s = x[7];
      SIZE_DWORD: s = x[31];
      default:    s = x[DATA_W-1];
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/x86alu_exec.sv
// ----------------------------------------------------------------------------
// x86alu_exec: first execute stage
// Masks the operands, forms add/sub/logic/not/bt results with their flag
// updates, and starts the signed multiply with four 32x32 partial products.
// ----------------------------------------------------------------------------
module x86alu_exec (
  input  logic [3:0]                    func,
  input  logic [1:0]                    size_code,
  input  logic [63:0]                   operand_a,
  input  logic [63:0]                   operand_b,
  input  logic [3:0]                    cond_code,
  output x86alu_pkg::alu_ctl_t          ctl,
  output x86alu_pkg::mul_pp_t           pp
);

  logic [63:0] mask;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] b_op;
  logic        is_sub;
  logic        is_arith;
  logic [64:0] sum;
  logic [63:0] res_arith;
  logic [63:0] res_logic;
  logic [63:0] nib_x;
  logic        carry;
  logic        sa;
  logic        sb;
  logic        sr;
  logic [5:0]  bit_idx;
  logic [63:0] a_sx;
  logic [63:0] b_sx;
  x86alu_pkg::func_t fn;

  assign fn   = x86alu_pkg::func_t'(func);
  assign mask = x86alu_pkg::size_mask(size_code);
  assign a    = operand_a & mask;
  assign b    = operand_b & mask;

  // Shared adder for add, sub, cmp, inc and dec.
  assign is_sub   = fn inside {x86alu_pkg::FUNC_SUB, x86alu_pkg::FUNC_CMP,
                               x86alu_pkg::FUNC_DEC};
  assign is_arith = is_sub || fn inside {x86alu_pkg::FUNC_ADD, x86alu_pkg::FUNC_INC};
  assign b_op     = (fn inside {x86alu_pkg::FUNC_INC, x86alu_pkg::FUNC_DEC}) ? 64'd1 : b;
  assign sum      = is_sub ? ({1'b0, a} - {1'b0, b_op}) : ({1'b0, a} + {1'b0, b_op});
  assign res_arith = sum[63:0] & mask;
  assign nib_x    = a ^ b_op ^ sum[63:0];

  // Carry or borrow out of the top bit of the operand size.
  always_comb begin
    case (size_code)
      x86alu_pkg::SIZE_BYTE:  carry = sum[8];
      x86alu_pkg::SIZE_DWORD: carry = sum[32];
      default:                carry = sum[64];
    endcase
  end

  assign sa = x86alu_pkg::sign_of(a, size_code);
  assign sb = x86alu_pkg::sign_of(b_op, size_code);
  assign sr = x86alu_pkg::sign_of(res_arith, size_code);

  // Logic results.
  always_comb begin
    case (fn)
      x86alu_pkg::FUNC_AND: res_logic = a & b;
      x86alu_pkg::FUNC_OR:  res_logic = a | b;
      default:              res_logic = a ^ b;
    endcase
  end

  // Bit index for bt is taken modulo the operand width.
  always_comb begin
    case (size_code)
      x86alu_pkg::SIZE_BYTE:  bit_idx = {3'b000, b[2:0]};
      x86alu_pkg::SIZE_DWORD: bit_idx = {1'b0, b[4:0]};
      default:                bit_idx = b[5:0];
    endcase
  end

  // Sign-extended operands for the multiply.
  always_comb begin
    case (size_code)
      x86alu_pkg::SIZE_BYTE: begin
        a_sx = {{56{a[7]}}, a[7:0]};
        b_sx = {{56{b[7]}}, b[7:0]};
      end
      x86alu_pkg::SIZE_DWORD: begin
        a_sx = {{32{a[31]}}, a[31:0]};
        b_sx = {{32{b[31]}}, b[31:0]};
      end
      default: begin
        a_sx = a;
        b_sx = b;
      end
    endcase
  end

  // Partial products of the unsigned 64x64 core.
  assign pp.p00  = {32'b0, a_sx[31:0]}  * {32'b0, b_sx[31:0]};
  assign pp.p01  = {32'b0, a_sx[31:0]}  * {32'b0, b_sx[63:32]};
  assign pp.p10  = {32'b0, a_sx[63:32]} * {32'b0, b_sx[31:0]};
  assign pp.p11  = {32'b0, a_sx[63:32]} * {32'b0, b_sx[63:32]};
  assign pp.a_sx = a_sx;
  assign pp.b_sx = b_sx;

  // Result, write-back and flag update per function.
  always_comb begin
    ctl            = '0;
    ctl.cond_code  = cond_code;
    ctl.size_code  = size_code;
    if (is_arith) begin
      ctl.result                        = res_arith;
      ctl.write_back                    = (fn != x86alu_pkg::FUNC_CMP);
      ctl.upd.wmask                     = '1;
      ctl.upd.value[x86alu_pkg::FLAG_CF] = carry;
      ctl.upd.value[x86alu_pkg::FLAG_PF] = ~^res_arith[7:0];
      ctl.upd.value[x86alu_pkg::FLAG_AF] = nib_x[4];
      ctl.upd.value[x86alu_pkg::FLAG_ZF] = (res_arith == 64'd0);
      ctl.upd.value[x86alu_pkg::FLAG_SF] = sr;
      ctl.upd.value[x86alu_pkg::FLAG_OF] = is_sub ? ((sa != sb) && (sa != sr))
                                                  : ((sa == sb) && (sa != sr));
    end else begin
      case (fn)
        x86alu_pkg::FUNC_AND, x86alu_pkg::FUNC_OR, x86alu_pkg::FUNC_XOR: begin
          ctl.result                         = res_logic;
          ctl.write_back                     = 1'b1;
          ctl.upd.wmask                      = '1;
          ctl.upd.value[x86alu_pkg::FLAG_PF] = ~^res_logic[7:0];
          ctl.upd.value[x86alu_pkg::FLAG_ZF] = (res_logic == 64'd0);
          ctl.upd.value[x86alu_pkg::FLAG_SF] = x86alu_pkg::sign_of(res_logic, size_code);
        end
        x86alu_pkg::FUNC_NOT: begin
          ctl.result     = ~a & mask;
          ctl.write_back = 1'b1;
        end
        x86alu_pkg::FUNC_IMUL: begin
          ctl.is_mul                         = 1'b1;
          ctl.write_back                     = 1'b1;
          ctl.upd.wmask[x86alu_pkg::FLAG_CF] = 1'b1;
          ctl.upd.wmask[x86alu_pkg::FLAG_OF] = 1'b1;
        end
        x86alu_pkg::FUNC_BT: begin
          ctl.upd.wmask[x86alu_pkg::FLAG_CF] = 1'b1;
          ctl.upd.value[x86alu_pkg::FLAG_CF] = a[bit_idx];
        end
        x86alu_pkg::FUNC_CONDTEST: begin
          ctl.is_cond = 1'b1;
        end
        default: begin
          ctl.is_cond = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/x86alu_mul_reduce.sv
// ----------------------------------------------------------------------------
// x86alu_mul_reduce: second execute stage
// Sums the partial product columns and forms the signed correction term
// that turns the unsigned high word into the signed one.
// ----------------------------------------------------------------------------
module x86alu_mul_reduce (
  input  x86alu_pkg::mul_pp_t  pp,
  output x86alu_pkg::mul_sum_t ms
);

  // Middle column: carries from the low word into the high word.
  assign ms.mid     = {2'b00, pp.p00[63:32]} + {2'b00, pp.p01[31:0]} + {2'b00, pp.p10[31:0]};
  assign ms.lo_low  = pp.p00[31:0];
  assign ms.hi_part = pp.p11 + {32'b0, pp.p01[63:32]} + {32'b0, pp.p10[63:32]};

  // Each negative operand subtracts the other operand from the high word.
  assign ms.corr = (pp.a_sx[63] ? pp.b_sx : 64'd0) + (pp.b_sx[63] ? pp.a_sx : 64'd0);

endmodule

FILE: hw/rtl/x86alu_mul_final.sv
// ----------------------------------------------------------------------------
// x86alu_mul_final: third execute stage
// Assembles the low product word and applies the carry and sign
// correction to the high word.
// ----------------------------------------------------------------------------
module x86alu_mul_final (
  input  x86alu_pkg::mul_sum_t  ms,
  output x86alu_pkg::mul_prod_t prod
);

  assign prod.lo = {ms.mid[31:0], ms.lo_low};
  assign prod.hi = ms.hi_part + {62'b0, ms.mid[33:32]} - ms.corr;

endmodule

FILE: hw/rtl/x86alu_commit.sv
// ----------------------------------------------------------------------------
// x86alu_commit: commit stage
// Judges multiply overflow, merges the flag update into the architectural
// flags and evaluates the condition test against the current flags.
// ----------------------------------------------------------------------------
module x86alu_commit (
  input  x86alu_pkg::alu_ctl_t  ctl,
  input  x86alu_pkg::mul_prod_t prod,
  input  logic [5:0]            flags_cur,
  output logic [63:0]           result,
  output logic                  write_back,
  output logic [5:0]            flags_nxt,
  output logic                  cond_true
);

  logic       fits;
  logic       hi_ok;
  logic       mul_ovf;
  logic [5:0] upd_value;
  logic       t;
  logic       cf;
  logic       pf;
  logic       zf;
  logic       sf;
  logic       of;

  // The product fits when the high bits are all copies of the size sign bit.
  always_comb begin
    case (ctl.size_code)
      x86alu_pkg::SIZE_BYTE:  fits = (&prod.lo[63:7]) | ~(|prod.lo[63:7]);
      x86alu_pkg::SIZE_DWORD: fits = (&prod.lo[63:31]) | ~(|prod.lo[63:31]);
      default:                fits = 1'b1;
    endcase
  end

  assign hi_ok   = (prod.hi == {64{prod.lo[63]}});
  assign mul_ovf = ~(fits & hi_ok);

  // Multiply supplies CF and OF here; all other functions came ready.
  always_comb begin
    upd_value = ctl.upd.value;
    if (ctl.is_mul) begin
      upd_value[x86alu_pkg::FLAG_CF] = mul_ovf;
      upd_value[x86alu_pkg::FLAG_OF] = mul_ovf;
    end
  end

  assign flags_nxt  = (flags_cur & ~ctl.upd.wmask) | (upd_value & ctl.upd.wmask);
  assign result     = ctl.is_mul ? (prod.lo & x86alu_pkg::size_mask(ctl.size_code))
                                 : ctl.result;
  assign write_back = ctl.write_back;

  // Condition test on the flags left by all earlier operations.
  assign cf = flags_cur[x86alu_pkg::FLAG_CF];
  assign pf = flags_cur[x86alu_pkg::FLAG_PF];
  assign zf = flags_cur[x86alu_pkg::FLAG_ZF];
  assign sf = flags_cur[x86alu_pkg::FLAG_SF];
  assign of = flags_cur[x86alu_pkg::FLAG_OF];

  always_comb begin
    case (x86alu_pkg::cond_grp_t'(ctl.cond_code[3:1]))
      x86alu_pkg::COND_O:  t = of;
      x86alu_pkg::COND_B:  t = cf;
      x86alu_pkg::COND_E:  t = zf;
      x86alu_pkg::COND_BE: t = cf | zf;
      x86alu_pkg::COND_S:  t = sf;
      x86alu_pkg::COND_P:  t = pf;
      x86alu_pkg::COND_L:  t = sf ^ of;
      default:             t = zf | (sf ^ of);
    endcase
  end

  assign cond_true = ctl.is_cond & (t ^ ctl.cond_code[0]);

endmodule

FILE: hw/rtl/x86_integer_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags: pipelined x86 integer ALU with flag register
// Add, sub, cmp, logic, inc, dec, not, signed multiply, bit test and
// condition test at 8, 32 or 64 bits, keeping the six arithmetic flags.
//
//   Channel  Ports                                          Dir  Handshake
//   input    in_func in_size_code in_operand_a/_b           in   in_valid/in_ready
//            in_cond_code
//   result   out_result out_write_back out_flags_out        out  out_valid/out_ready
//            out_cond_true
//
// One beat is accepted per cycle while the pipeline is not stalled; each beat
// passes the input register, then three execute stage registers, then the
// output register.
// The 64x64 multiply sets the depth: partial products, column sums, then
// the high-word correction each take one stage.
// Flags are read and written only at the commit into the output register,
// so every beat sees the flags of all earlier beats without stalls.
// Each stage holds while its successor is full and stalled; bubbles close up.
// Reset clears the stage valid bits and the flags.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_func,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic [3:0]  in_cond_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  output logic        out_write_back,
  output logic [5:0]  out_flags_out,
  output logic        out_cond_true
);

  // Stage valid bits and enables.
  logic v0_r, v1_r, v2_r, v3_r, vout_r;
  logic en0, en1, en2, en3, en_out;
  logic commit_go;

  // Input register.
  logic [3:0]  func_r;
  logic [1:0]  size_r;
  logic [63:0] opa_r;
  logic [63:0] opb_r;
  logic [3:0]  cc_r;

  // Stage payloads.
  x86alu_pkg::alu_ctl_t  ctl_nxt, ctl1_r, ctl2_r, ctl3_r;
  x86alu_pkg::mul_pp_t   pp_nxt, pp1_r;
  x86alu_pkg::mul_sum_t  ms_nxt, ms2_r;
  x86alu_pkg::mul_prod_t prod_nxt, prod3_r;

  // Flags and output register.
  logic [5:0]  flags_r, flags_nxt;
  logic [63:0] result_nxt, result_r;
  logic        wb_nxt, wb_r;
  logic        ct_nxt, ct_r;

  // Ready chain: a stage loads when it is empty or its content moves on.
  assign en_out    = ~vout_r | out_ready;
  assign en3       = ~v3_r | en_out;
  assign en2       = ~v2_r | en3;
  assign en1       = ~v1_r | en2;
  assign en0       = ~v0_r | en1;
  assign in_ready  = en0;
  assign commit_go = en_out & v3_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      if (en0)    v0_r   <= in_valid;
      if (en1)    v1_r   <= v0_r;
      if (en2)    v2_r   <= v1_r;
      if (en3)    v3_r   <= v2_r;
      if (en_out) vout_r <= v3_r;
    end
  end

  // Flag register, written only when a beat commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (commit_go) begin
      flags_r <= flags_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en0) begin
      func_r <= in_func;
      size_r <= in_size_code;
      opa_r  <= in_operand_a;
      opb_r  <= in_operand_b;
      cc_r   <= in_cond_code;
    end
  end

  x86alu_exec u_exec (
    .func      (func_r),
    .size_code (size_r),
    .operand_a (opa_r),
    .operand_b (opb_r),
    .cond_code (cc_r),
    .ctl       (ctl_nxt),
    .pp        (pp_nxt)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r <= ctl_nxt;
      pp1_r  <= pp_nxt;
    end
  end

  x86alu_mul_reduce u_mul_reduce (
    .pp (pp1_r),
    .ms (ms_nxt)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2_r <= ctl1_r;
      ms2_r  <= ms_nxt;
    end
  end

  x86alu_mul_final u_mul_final (
    .ms   (ms2_r),
    .prod (prod_nxt)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      ctl3_r  <= ctl2_r;
      prod3_r <= prod_nxt;
    end
  end

  x86alu_commit u_commit (
    .ctl        (ctl3_r),
    .prod       (prod3_r),
    .flags_cur  (flags_r),
    .result     (result_nxt),
    .write_back (wb_nxt),
    .flags_nxt  (flags_nxt),
    .cond_true  (ct_nxt)
  );

  // Output register; the flags travel in flags_r itself.
  always_ff @(posedge clk) begin
    if (en_out) begin
      result_r <= result_nxt;
      wb_r     <= wb_nxt;
      ct_r     <= ct_nxt;
    end
  end

  assign out_valid      = vout_r;
  assign out_result     = result_r;
  assign out_write_back = wb_r;
  assign out_flags_out  = flags_r;
  assign out_cond_true  = ct_r;

`ifndef SYNTHESIS
  // Flags move only when a beat commits.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit_go |=> (flags_r == $past(flags_r)))
    else $error("flag register changed without a commit");

  // A committed beat leaves the output valid in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_valid)
    else $error("committed beat did not reach the output register");

  // A true condition comes only from a condition test, which writes nothing.
  a_cond_nowb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cond_true) |-> (!out_write_back && (out_result == 64'd0)))
    else $error("condition result carries write-back or data");
`endif

endmodule

FILE: verif/x86_integer_alu_with_flags_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_checker: result scoreboard for the x86 ALU
// Watches both channels of the ALU. Each accepted input beat runs through
// a behavioral model of the ALU that keeps its own copy of the flag word.
// Every accepted result beat is compared field by field against the oldest
// prediction. The mismatch count and the number of results still owed are
// handed back to the test top.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_checker
  import x86alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_func,
  input  logic [1:0]  in_size_code,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic [3:0]  in_cond_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result,
  input  logic        out_write_back,
  input  logic [5:0]  out_flags_out,
  input  logic        out_cond_true,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0]       result;
    logic              write_back;
    logic [FLAG_W-1:0] flags;
    logic              cond_true;
  } alu_outcome_t;

  alu_outcome_t      expected_outcomes[$];
  logic [FLAG_W-1:0] flag_state;
  int                mismatches = 0;

  // Zero, sign and parity flags of a result; every other flag is clear.
  function automatic logic [FLAG_W-1:0] zsp_flags(input logic [63:0] res,
                                                  input logic [63:0] top);
    logic [FLAG_W-1:0] f;
    f          = '0;
    f[FLAG_ZF] = (res == 64'd0);
    f[FLAG_SF] = |(res & top);
    f[FLAG_PF] = ~^res[7:0];
    return f;
  endfunction

  // Behavioral model of one ALU operation against the current flag word.
  function automatic alu_outcome_t exec_x86_op(input logic [3:0]        func,
                                               input logic [1:0]        size,
                                               input logic [63:0]       opa,
                                               input logic [63:0]       opb,
                                               input logic [3:0]        cc,
                                               input logic [FLAG_W-1:0] flags_in);
    logic [63:0]       m;
    logic [63:0]       top;
    logic [5:0]        idx_mask;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [63:0]       a_sx;
    logic [63:0]       b_sx;
    logic [63:0]       res_sx;
    logic [127:0]      prod;
    logic              sa;
    logic              sb;
    logic              sr;
    logic              t;
    alu_outcome_t      o;
    case (size)
      SIZE_BYTE: begin
        m        = 64'h0000_0000_0000_00FF;
        top      = 64'h0000_0000_0000_0080;
        idx_mask = 6'd7;
      end
      SIZE_DWORD: begin
        m        = 64'h0000_0000_FFFF_FFFF;
        top      = 64'h0000_0000_8000_0000;
        idx_mask = 6'd31;
      end
      default: begin
        // The spare size code behaves as 64-bit.
        m        = '1;
        top      = 64'h8000_0000_0000_0000;
        idx_mask = 6'd63;
      end
    endcase
    a            = opa & m;
    b            = opb & m;
    o.result     = '0;
    o.write_back = 1'b0;
    o.flags      = flags_in;
    o.cond_true  = 1'b0;
    case (func)
      FUNC_ADD, FUNC_INC: begin
        if (func == FUNC_INC) b = 64'd1;
        o.result         = (a + b) & m;
        sa               = |(a & top);
        sb               = |(b & top);
        sr               = |(o.result & top);
        o.flags          = zsp_flags(o.result, top);
        o.flags[FLAG_CF] = o.result < a;
        o.flags[FLAG_OF] = (sa == sb) && (sa != sr);
        o.flags[FLAG_AF] = o.result[3:0] < a[3:0];
        o.write_back     = 1'b1;
      end
      FUNC_SUB, FUNC_CMP, FUNC_DEC: begin
        if (func == FUNC_DEC) b = 64'd1;
        o.result         = (a - b) & m;
        sa               = |(a & top);
        sb               = |(b & top);
        sr               = |(o.result & top);
        o.flags          = zsp_flags(o.result, top);
        o.flags[FLAG_CF] = a < b;
        o.flags[FLAG_OF] = (sa != sb) && (sa != sr);
        o.flags[FLAG_AF] = a[3:0] < b[3:0];
        // Compare keeps the difference on the bus but does not write it.
        o.write_back     = (func != FUNC_CMP);
      end
      FUNC_AND, FUNC_OR, FUNC_XOR: begin
        if (func == FUNC_AND)     o.result = a & b;
        else if (func == FUNC_OR) o.result = a | b;
        else                      o.result = a ^ b;
        o.flags      = zsp_flags(o.result, top);
        o.write_back = 1'b1;
      end
      FUNC_NOT: begin
        o.result     = ~a & m;
        o.write_back = 1'b1;
      end
      FUNC_IMUL: begin
        // Exact signed product; CF and OF flag a product that does not fit.
        a_sx             = (a ^ top) - top;
        b_sx             = (b ^ top) - top;
        prod             = {{64{a_sx[63]}}, a_sx} * {{64{b_sx[63]}}, b_sx};
        o.result         = prod[63:0] & m;
        res_sx           = (o.result ^ top) - top;
        o.flags[FLAG_CF] = prod != {{64{res_sx[63]}}, res_sx};
        o.flags[FLAG_OF] = o.flags[FLAG_CF];
        o.write_back     = 1'b1;
      end
      FUNC_BT: begin
        o.flags[FLAG_CF] = a[b[5:0] & idx_mask];
      end
      FUNC_CONDTEST: begin
        case (cc[3:1])
          COND_O:  t = flags_in[FLAG_OF];
          COND_B:  t = flags_in[FLAG_CF];
          COND_E:  t = flags_in[FLAG_ZF];
          COND_BE: t = flags_in[FLAG_CF] | flags_in[FLAG_ZF];
          COND_S:  t = flags_in[FLAG_SF];
          COND_P:  t = flags_in[FLAG_PF];
          COND_L:  t = flags_in[FLAG_SF] ^ flags_in[FLAG_OF];
          default: t = flags_in[FLAG_ZF] | (flags_in[FLAG_SF] ^ flags_in[FLAG_OF]);
        endcase
        o.cond_true = t ^ cc[0];
      end
      default: begin
        // Spare function codes leave everything untouched.
      end
    endcase
    return o;
  endfunction

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Retire result beats against the oldest prediction, then predict new input beats.
  always @(posedge clk) begin
    alu_outcome_t want;
    if (!rst_n) begin
      expected_outcomes.delete();
      flag_state = '0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result beat with no prediction waiting, expected none, actual %h",
                   $time, out_result);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          report_field("result", want.result, out_result);
          report_field("write_back", 64'(want.write_back), 64'(out_write_back));
          report_field("flags_out", 64'(want.flags), 64'(out_flags_out));
          report_field("cond_true", 64'(want.cond_true), 64'(out_cond_true));
        end
      end
      if (in_valid && in_ready) begin
        want = exec_x86_op(in_func, in_size_code, in_operand_a, in_operand_b,
                           in_cond_code, flag_state);
        flag_state = want.flags;
        expected_outcomes.push_back(want);
      end
      pending <= expected_outcomes.size();
    end
    fail_count <= mismatches;
  end

endmodule

FILE: verif/x86_integer_alu_with_flags_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_test: stimulus and verdict for the x86 ALU
// Drives a directed set of flag corner cases followed by random operations
// at all operand sizes, with random gaps on the input side and random stalls
// on the result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_test;
  import x86alu_pkg::*;

  localparam int RANDOM_OPS = 900;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  // Jump condition codes used by the directed part.
  localparam logic [3:0] JCC_O  = 4'h0;
  localparam logic [3:0] JCC_AE = 4'h3;
  localparam logic [3:0] JCC_E  = 4'h4;
  localparam logic [3:0] JCC_A  = 4'h7;
  localparam logic [3:0] JCC_NS = 4'h9;
  localparam logic [3:0] JCC_P  = 4'hA;
  localparam logic [3:0] JCC_GE = 4'hD;
  localparam logic [3:0] JCC_LE = 4'hE;

  // Codes the block does not define.
  localparam logic [3:0] FUNC_SPARE_LO = 4'd12;
  localparam logic [3:0] FUNC_SPARE_HI = 4'd15;
  localparam logic [1:0] SIZE_SPARE    = 2'd3;

  localparam logic [63:0] MSB64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_func;
  logic [1:0]  in_size_code;
  logic [63:0] in_operand_a;
  logic [63:0] in_operand_b;
  logic [3:0]  in_cond_code;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result;
  logic        out_write_back;
  logic [5:0]  out_flags_out;
  logic        out_cond_true;

  int mismatch_count;
  int outstanding;
  int ops_sent;
  int results_seen = 0;
  int idle_cycles = 0;
  bit no_gaps;

  x86_integer_alu_with_flags dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_size_code   (in_size_code),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_cond_code   (in_cond_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_write_back (out_write_back),
    .out_flags_out  (out_flags_out),
    .out_cond_true  (out_cond_true)
  );

  x86_integer_alu_with_flags_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_size_code   (in_size_code),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_cond_code   (in_cond_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_write_back (out_write_back),
    .out_flags_out  (out_flags_out),
    .out_cond_true  (out_cond_true),
    .fail_count     (mismatch_count),
    .pending        (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand mix: full random, small signed, boundary values and shifted random.
  function automatic logic [63:0] rand_operand();
    logic [4:0] v;
    case ($urandom_range(0, 4))
      0, 1: return {$urandom, $urandom};
      2: begin
        v = 5'($urandom_range(0, 31));
        return {{59{v[4]}}, v};
      end
      3: begin
        case ($urandom_range(0, 7))
          0: return 64'd0;
          1: return ONES;
          2: return 64'h80;
          3: return 64'h7F;
          4: return 64'h7FFF_FFFF;
          5: return 64'h8000_0000;
          6: return MSB64;
          default: return ~MSB64;
        endcase
      end
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  // Present one input beat after a random gap and hold it until accepted.
  task automatic send_op(input logic [3:0] func, input logic [1:0] size,
                         input logic [63:0] a, input logic [63:0] b,
                         input logic [3:0] cc);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_size_code <= size;
    in_operand_a <= a;
    in_operand_b <= b;
    in_cond_code <= cc;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
  endtask

  // Result side: ready runs of random length broken by random stalls.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      int stall;
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 150)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) results_seen++;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [3:0] fn;
    logic [1:0] sz;
    int         r;
    ops_sent     = 0;
    no_gaps      = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = '0;
    in_size_code = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_cond_code = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners, with condition tests reading the flags just made.
    send_op(FUNC_ADD, SIZE_BYTE, ONES, 64'd1, JCC_O);
    send_op(FUNC_ADD, SIZE_BYTE, 64'h7F, 64'd1, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_BYTE, 64'd0, 64'd0, JCC_O);
    send_op(FUNC_SUB, SIZE_DWORD, 64'd0, 64'd1, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_DWORD, 64'd0, 64'd0, JCC_AE);
    send_op(FUNC_SUB, SIZE_QWORD, MSB64, 64'd1, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_QWORD, 64'd0, 64'd0, JCC_GE);
    send_op(FUNC_CMP, SIZE_QWORD, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_QWORD, ONES, ONES, JCC_E);
    send_op(FUNC_CONDTEST, SIZE_QWORD, ONES, ONES, JCC_A);
    send_op(FUNC_AND, SIZE_QWORD, ONES, MSB64, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_QWORD, 64'd0, 64'd0, JCC_NS);
    send_op(FUNC_OR, SIZE_BYTE, 64'hFFFF_FF00, 64'h00FF_FF00, JCC_O);
    send_op(FUNC_XOR, SIZE_DWORD, 64'hFFFF_FFFF_0F0F_0F0F, 64'h0000_0000_F0F0_F0F1, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_DWORD, 64'd0, 64'd0, JCC_P);
    send_op(FUNC_INC, SIZE_BYTE, 64'hFF, 64'd0, JCC_O);
    send_op(FUNC_DEC, SIZE_QWORD, 64'd0, ONES, JCC_O);
    send_op(FUNC_CONDTEST, SIZE_QWORD, 64'd0, 64'd0, JCC_LE);
    send_op(FUNC_NOT, SIZE_SPARE, ONES, 64'd0, JCC_O);
    send_op(FUNC_IMUL, SIZE_BYTE, 64'h80, 64'hFF, JCC_O);
    send_op(FUNC_IMUL, SIZE_QWORD, ONES, ONES, JCC_O);
    send_op(FUNC_IMUL, SIZE_QWORD, MSB64, ONES, JCC_O);
    send_op(FUNC_IMUL, SIZE_DWORD, 64'h1_0000, 64'h1_0000, JCC_O);
    send_op(FUNC_BT, SIZE_BYTE, 64'h80, ONES, JCC_O);
    send_op(FUNC_BT, SIZE_QWORD, MSB64, 64'd63, JCC_O);
    send_op(FUNC_SPARE_LO, SIZE_QWORD, ONES, ONES, 4'hF);
    send_op(FUNC_SPARE_HI, SIZE_SPARE, ONES, ONES, 4'hF);

    // Random operations; some stretches run with no input gaps at all.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      r  = $urandom_range(0, 99);
      fn = (r < 94) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
      r  = $urandom_range(0, 15);
      if (r < 5)       sz = SIZE_BYTE;
      else if (r < 10) sz = SIZE_DWORD;
      else if (r < 15) sz = SIZE_QWORD;
      else             sz = SIZE_SPARE;
      send_op(fn, sz, rand_operand(), rand_operand(), 4'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    // Let the last prediction land, then drain the pipeline.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations over every function, spare code, size and jump condition.",
             ops_sent);
    $display("Compared %0d results in order; %0d still owed at the end.",
             results_seen, outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/x86alu_pkg.sv
hw/rtl/x86alu_exec.sv
hw/rtl/x86alu_mul_reduce.sv
hw/rtl/x86alu_mul_final.sv
hw/rtl/x86alu_commit.sv
hw/rtl/x86_integer_alu_with_flags.sv
verif/x86_integer_alu_with_flags_checker.sv
verif/x86_integer_alu_with_flags_test.sv
